FILE: rtl/pcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_pkg: shared types and constants of the clamped PID controller
// Sequencer states, multiply operation codes, register indexes, saturation
// limits and small arithmetic helpers.
// ----------------------------------------------------------------------------
package pcc_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL,
        ST_POST,
        ST_DIV,
        ST_DFIN,
        ST_SUM,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_INC,
        OP_P,
        OP_I,
        OP_V
    } t_op;

    typedef enum logic [2:0] {
        REG_KP   = 3'd0,
        REG_KI   = 3'd1,
        REG_KD   = 3'd2,
        REG_STEP = 3'd3,
        REG_OMIN = 3'd4,
        REG_OMAX = 3'd5
    } t_reg;

    localparam int ACC_W      = 80;
    localparam int TERM_W     = 61;
    localparam int INTEG_W    = 48;
    localparam int DIV_W      = 62;
    localparam int DIV_CYCLES = DIV_W / 2;
    localparam int VLIM_W     = TERM_W - 16;

    localparam logic [TERM_W-1:0] TERM_MAX   = '1;
    localparam logic [15:0]       STEP_RESET = 16'd655;
    localparam logic [31:0]       OMAX_RESET = 32'd6553600;

    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? (32'd0 - x) : x;
    endfunction

    function automatic logic [32:0] mag33(input logic [32:0] x);
        return x[32] ? (33'd0 - x) : x;
    endfunction

    function automatic logic [47:0] mag48(input logic [47:0] x);
        return x[47] ? (48'd0 - x) : x;
    endfunction

    // One restoring division step: {quotient bit, new remainder}
    function automatic logic [16:0] div_step(input logic [15:0] rem, input logic din,
                                             input logic [15:0] den);
        logic [16:0] t;
        t = {rem, din};
        if (t >= {1'b0, den}) begin
            return {1'b1, 16'(t - {1'b0, den})};
        end
        return {1'b0, t[15:0]};
    endfunction

endpackage
`default_nettype wire

FILE: rtl/pid_controller_clamped.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_controller_clamped: fixed-point PID controller with output clamp
// Samples are taken one at a time: a new input is accepted only once the
//   previous result is in the output register. The shared 32x16 multiplier
//   forms every product; the radix-4 divider is skipped when the derivative
//   term saturates.
// Reset (synchronous, active low): registers take their reset values, the
//   integral and previous error clear, no result is pending.
// ----------------------------------------------------------------------------
module pid_controller_clamped #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] setpoint, [63:32] measurement
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] drive
);
    import pcc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] r_kp, r_ki, r_kd, r_out_min, r_out_max;
    logic [15:0] r_step;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp      <= '0;
            r_ki      <= '0;
            r_kd      <= '0;
            r_step    <= STEP_RESET;
            r_out_min <= '0;
            r_out_max <= OMAX_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_KP:   r_kp      <= pwdata;
                REG_KI:   r_ki      <= pwdata;
                REG_KD:   r_kd      <= pwdata;
                REG_STEP: r_step    <= pwdata[15:0];
                REG_OMIN: r_out_min <= pwdata;
                REG_OMAX: r_out_max <= pwdata;
                default:  ;  // unmapped: drop the write
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_KP:   prdata = r_kp;
            REG_KI:   prdata = r_ki;
            REG_KD:   prdata = r_kd;
            REG_STEP: prdata = {16'd0, r_step};
            REG_OMIN: prdata = r_out_min;
            REG_OMAX: prdata = r_out_max;
            default:  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [1:0]         r_chunk, n_chunk;     // 16-bit slice of the B operand
    logic [4:0]         r_cnt, n_cnt;         // divider cycle count
    logic [31:0]        r_e, n_e;             // saturated error
    logic [31:0]        r_last, n_last;       // previous error
    logic [32:0]        r_delta, n_delta;     // e - previous error, exact
    logic [INTEG_W-1:0] r_integ, n_integ;     // Q32.16 error integral
    logic [31:0]        r_a, n_a;             // multiplier A magnitude
    logic [47:0]        r_b, n_b;             // multiplier B magnitude
    logic               r_neg, n_neg;         // sign of the current product
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [63:0]        r_p, n_p, r_i, n_i, r_d, n_d, r_sum, n_sum;
    logic [DIV_W-1:0]   r_quo, n_quo;         // dividend in, quotient out
    logic [15:0]        r_rem, n_rem;
    logic               r_out_valid, n_out_valid;
    logic [31:0]        r_drive, n_drive;

    // dt of zero behaves as one
    logic [15:0] dt;
    assign dt = (r_step == 16'd0) ? 16'd1 : r_step;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_drive;

    // Error of the incoming sample, saturated to 32 bits
    logic [32:0] e_diff;
    logic [31:0] e_sat;
    assign e_diff = {s_axis_tdata[31], s_axis_tdata[31:0]}
                  - {s_axis_tdata[63], s_axis_tdata[63:32]};
    assign e_sat  = (e_diff[32] != e_diff[31])
                  ? (e_diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : e_diff[31:0];

    // Shared multiplier: one 32x16 partial product per cycle into the
    // accumulator at the slice's offset
    logic [15:0]      b_slice;
    logic [47:0]      prod;
    logic [ACC_W-1:0] prod_sh;
    logic [ACC_W-1:0] acc_sum;
    logic [1:0]       last_chunk;

    always_comb begin
        case (r_chunk)
            2'd0:    b_slice = r_b[15:0];
            2'd1:    b_slice = r_b[31:16];
            default: b_slice = r_b[47:32];
        endcase
    end

    assign prod = r_a * b_slice;

    always_comb begin
        case (r_chunk)
            2'd0:    prod_sh = {32'd0, prod};
            2'd1:    prod_sh = {16'd0, prod, 16'd0};
            default: prod_sh = {prod, 32'd0};
        endcase
    end

    assign acc_sum = ((r_chunk == 2'd0) ? '0 : r_acc) + prod_sh;

    always_comb begin
        case (r_op)
            OP_INC:  last_chunk = 2'd0;
            OP_P:    last_chunk = 2'd1;
            default: last_chunk = 2'd2;
        endcase
    end

    // Gain product post-processing: shift out the fraction, limit, sign
    logic [ACC_W-1:0]  acc_shr;
    logic [TERM_W-1:0] term_mag;
    logic [63:0]       term_pos, term;
    logic              v_big;

    assign acc_shr  = r_acc >> FRAC_BITS;
    assign term_mag = (acc_shr > ACC_W'(TERM_MAX)) ? TERM_MAX : acc_shr[TERM_W-1:0];
    assign term_pos = 64'(term_mag);
    assign term     = r_neg ? (64'd0 - term_pos) : term_pos;
    // derivative saturates outright once |v| exceeds TERM_MAX / 2^16
    assign v_big    = |term_mag[TERM_W-1:VLIM_W];

    // Integral update: inc = +-(|e|*dt >> 16), saturating 48-bit sum
    logic [48:0] inc;
    logic [48:0] integ_sum;
    logic [47:0] integ_sat;
    assign inc       = r_neg ? (49'd0 - {17'd0, r_acc[47:16]}) : {17'd0, r_acc[47:16]};
    assign integ_sum = {r_integ[47], r_integ} + inc;
    assign integ_sat = (integ_sum[48] != integ_sum[47])
                     ? {integ_sum[48], {47{~integ_sum[48]}}} : integ_sum[47:0];

    // Divider: two restoring steps per cycle
    logic [16:0] dstep1, dstep2;
    assign dstep1 = div_step(r_rem, r_quo[DIV_W-1], dt);
    assign dstep2 = div_step(dstep1[15:0], r_quo[DIV_W-2], dt);

    // Output clamp: upper limit first, lower limit wins when crossed
    logic [63:0] omax_ext, omin_ext, clamp_hi;
    logic [31:0] drive_val;
    assign omax_ext  = {{32{r_out_max[31]}}, r_out_max};
    assign omin_ext  = {{32{r_out_min[31]}}, r_out_min};
    assign clamp_hi  = ($signed(r_sum) > $signed(omax_ext)) ? omax_ext : r_sum;
    assign drive_val = ($signed(clamp_hi) < $signed(omin_ext)) ? r_out_min : clamp_hi[31:0];

    logic out_free;
    assign out_free = !r_out_valid || m_axis_tready;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (s_axis_tvalid) n_state = ST_ERR;
            ST_ERR:  n_state = ST_MUL;
            ST_MUL:  if (r_chunk == last_chunk) n_state = ST_POST;
            ST_POST: begin
                if (r_op == OP_V) begin
                    n_state = v_big ? ST_SUM : ST_DIV;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_DIV:  if (r_cnt == 5'(DIV_CYCLES - 1)) n_state = ST_DFIN;
            ST_DFIN: n_state = ST_SUM;
            ST_SUM:  n_state = ST_DONE;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath controls per state
    // ------------------------------------------------------------------
    always_comb begin
        n_op        = r_op;
        n_chunk     = r_chunk;
        n_cnt       = r_cnt;
        n_e         = r_e;
        n_last      = r_last;
        n_delta     = r_delta;
        n_integ     = r_integ;
        n_a         = r_a;
        n_b         = r_b;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_p         = r_p;
        n_i         = r_i;
        n_d         = r_d;
        n_sum       = r_sum;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_drive     = r_drive;
        // retire the pending result on its transfer
        n_out_valid = r_out_valid && !m_axis_tready;

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) n_e = e_sat;
            end
            ST_ERR: begin
                // capture the derivative difference, then advance the history
                n_delta = {r_e[31], r_e} - {r_last[31], r_last};
                n_last  = r_e;
                n_a     = mag32(r_e);
                n_b     = {32'd0, dt};
                n_neg   = r_e[31];
                n_op    = OP_INC;
                n_chunk = 2'd0;
            end
            ST_MUL: begin
                n_acc   = acc_sum;
                n_chunk = r_chunk + 2'd1;
            end
            ST_POST: begin
                n_chunk = 2'd0;
                case (r_op)
                    OP_INC: begin
                        n_integ = integ_sat;
                        n_a     = mag32(r_kp);
                        n_b     = {16'd0, mag32(r_e)};
                        n_neg   = r_kp[31] ^ r_e[31];
                        n_op    = OP_P;
                    end
                    OP_P: begin
                        n_p   = term;
                        n_a   = mag32(r_ki);
                        n_b   = mag48(r_integ);
                        n_neg = r_ki[31] ^ r_integ[47];
                        n_op  = OP_I;
                    end
                    OP_I: begin
                        n_i   = term;
                        n_a   = mag32(r_kd);
                        n_b   = {15'd0, mag33(r_delta)};
                        n_neg = r_kd[31] ^ r_delta[32];
                        n_op  = OP_V;
                    end
                    default: begin
                        if (v_big) begin
                            n_d = r_neg ? (64'd0 - 64'(TERM_MAX)) : 64'(TERM_MAX);
                        end else begin
                            // dividend is |v| * 2^16
                            n_quo = {1'b0, term_mag[VLIM_W-1:0], 16'd0};
                            n_rem = '0;
                            n_cnt = '0;
                        end
                    end
                endcase
            end
            ST_DIV: begin
                n_quo = {r_quo[DIV_W-3:0], dstep1[16], dstep2[16]};
                n_rem = dstep2[15:0];
                n_cnt = r_cnt + 5'd1;
            end
            ST_DFIN: begin
                n_d = r_neg ? (64'd0 - 64'(r_quo)) : 64'(r_quo);
            end
            ST_SUM: begin
                n_sum = r_p + r_i + r_d;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_drive     = drive_val;
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
            r_last      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_integ     <= n_integ;
            r_last      <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_chunk <= n_chunk;
        r_cnt   <= n_cnt;
        r_e     <= n_e;
        r_delta <= n_delta;
        r_a     <= n_a;
        r_b     <= n_b;
        r_neg   <= n_neg;
        r_acc   <= n_acc;
        r_p     <= n_p;
        r_i     <= n_i;
        r_d     <= n_d;
        r_sum   <= n_sum;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_drive <= n_drive;
    end

endmodule
`default_nettype wire

FILE: tb/pid_controller_clamped_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_clamped_tb: self-checking bench for the clamped PID controller
// Streams setpoint/measurement samples through the block under several gain,
// sample-period and clamp settings. A bit-accurate fixed-point model inside
// the bench predicts every drive value, and the output stream is checked
// against it in order. Registers are read back after each write to a mapped
// register. Flow control on both streams is randomized in four pacing modes.
// ----------------------------------------------------------------------------
module pid_controller_clamped_tb;
    import pcc_pkg::*;

    localparam int FRAC = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_CYCLES = 60;

    // Register indexes past the last real register; writes there must be ignored
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    // Saturation limits of the controller arithmetic
    localparam longint ERR_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint ERR_LO = 64'shFFFF_FFFF_8000_0000;
    localparam longint INTEG_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint INTEG_LO = 64'shFFFF_8000_0000_0000;
    localparam longint TERM_LIM = 64'sh1FFF_FFFF_FFFF_FFFF;
    localparam longint DERIV_V_LIM = 64'sh0000_1FFF_FFFF_FFFF;

    typedef struct packed {
        logic [31:0] setpoint;
        logic [31:0] measurement;
    } t_sample;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_data;

    // Controller model: configuration copy and running state
    longint      cfg_kp = 0;
    longint      cfg_ki = 0;
    longint      cfg_kd = 0;
    logic [15:0] cfg_step = STEP_RESET;
    longint      cfg_omin = 0;
    longint      cfg_omax = longint'(OMAX_RESET);
    longint      integ_acc = 0;
    longint      prev_err = 0;

    t_sample     pending_q[$];
    logic [31:0] drive_expect_q[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int samples_queued = 0;
    int samples_taken = 0;
    int drives_checked = 0;
    int settings_applied = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    pid_controller_clamped #(
        .FRAC_BITS(FRAC)
    ) DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),    // [31:0] setpoint, [63:32] measurement
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data)     // [31:0] drive
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Controller model
    // ------------------------------------------------------------------

    // (gain * x) / 2^FRAC, truncated toward zero, magnitude held to TERM_LIM
    function automatic longint gain_product(input longint gain, input longint x);
        logic [127:0] prod;
        longint       mag_g;
        longint       mag_x;
        longint       s;
        mag_g = (gain < 0) ? -gain : gain;
        mag_x = (x < 0) ? -x : x;
        prod = ({64'd0, mag_g} * {64'd0, mag_x}) >> FRAC;
        s = (prod > {64'd0, TERM_LIM}) ? TERM_LIM : longint'(prod[63:0]);
        return ((gain < 0) != (x < 0)) ? -s : s;
    endfunction

    // Advance the controller by one sample and return the clamped drive value
    function automatic logic [31:0] pid_drive(input logic [31:0] sp, input logic [31:0] pv);
        longint err;
        longint mag_err;
        longint inc;
        longint dt;
        longint p_term;
        longint i_term;
        longint d_term;
        longint v;
        longint total;
        // A zero sample period behaves as the smallest nonzero one
        dt = (cfg_step == 16'd0) ? 64'sd1 : longint'(cfg_step);
        err = longint'($signed(sp)) - longint'($signed(pv));
        if (err > ERR_HI) err = ERR_HI;
        if (err < ERR_LO) err = ERR_LO;

        mag_err = (err < 0) ? -err : err;
        inc = (mag_err * dt) >>> 16;
        integ_acc += (err < 0) ? -inc : inc;
        if (integ_acc > INTEG_HI) integ_acc = INTEG_HI;
        if (integ_acc < INTEG_LO) integ_acc = INTEG_LO;

        p_term = gain_product(cfg_kp, err);
        i_term = gain_product(cfg_ki, integ_acc);

        // Derivative saturates outright when the scaled value cannot fit
        v = gain_product(cfg_kd, err - prev_err);
        if (v > DERIV_V_LIM) begin
            d_term = TERM_LIM;
        end else if (v < -DERIV_V_LIM) begin
            d_term = -TERM_LIM;
        end else begin
            d_term = (v * 64'sd65536) / dt;
            if (d_term > TERM_LIM) d_term = TERM_LIM;
            if (d_term < -TERM_LIM) d_term = -TERM_LIM;
        end
        prev_err = err;

        // Upper clamp first, lower after: crossed limits yield out_min
        total = p_term + i_term + d_term;
        if (total > cfg_omax) total = cfg_omax;
        if (total < cfg_omin) total = cfg_omin;
        return total[31:0];
    endfunction

    function automatic void record_reg(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            REG_KP:   cfg_kp = longint'($signed(data));
            REG_KI:   cfg_ki = longint'($signed(data));
            REG_KD:   cfg_kd = longint'($signed(data));
            REG_STEP: cfg_step = data[15:0];
            REG_OMIN: cfg_omin = longint'($signed(data));
            REG_OMAX: cfg_omax = longint'($signed(data));
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] reg_image(input logic [2:0] idx);
        case (idx)
            REG_KP:   return cfg_kp[31:0];
            REG_KI:   return cfg_ki[31:0];
            REG_KD:   return cfg_kd[31:0];
            REG_STEP: return {16'd0, cfg_step};
            REG_OMIN: return cfg_omin[31:0];
            REG_OMAX: return cfg_omax[31:0];
            default:  return '0;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("ERROR: %s: expected %h, got %h at %0t", what, want, got, $realtime);
        end
    endtask

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------

    // Setup cycle, then access cycle; read data is taken as the access completes
    task automatic reg_access(input logic wr, input logic [2:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_reg(input logic [2:0] idx);
        logic [31:0] rd;
        reg_access(1'b0, idx, '0, rd);
        if (rd !== reg_image(idx)) begin
            flag_mismatch($sformatf("register %0d readback", idx), reg_image(idx), rd);
        end
    endtask

    task automatic program_reg(input logic [2:0] idx, input logic [31:0] data);
        logic [31:0] rd;
        reg_access(1'b1, idx, data, rd);
        record_reg(idx, data);
        if (idx <= REG_OMAX) begin
            check_reg(idx);
        end
    endtask

    task automatic apply_setting(input logic [31:0] kp, input logic [31:0] ki,
                                 input logic [31:0] kd, input logic [15:0] step,
                                 input logic [31:0] omin, input logic [31:0] omax);
        program_reg(REG_KP, kp);
        program_reg(REG_KI, ki);
        program_reg(REG_KD, kd);
        // Upper half of the period word is don't-care; fill it with noise
        program_reg(REG_STEP, {16'($urandom()), step});
        program_reg(REG_OMIN, omin);
        program_reg(REG_OMAX, omax);
        settings_applied++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [31:0] pick_corner();
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return pick_corner();
            default: return $urandom_range(0, 1 << 21) - (1 << 20);
        endcase
    endfunction

    function automatic logic [15:0] pick_step();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            default: return 16'($urandom_range(64, 4096));
        endcase
    endfunction

    task automatic queue_sample(input logic [31:0] sp, input logic [31:0] pv);
        t_sample s;
        s.setpoint = sp;
        s.measurement = pv;
        pending_q.push_back(s);
        samples_queued++;
    endtask

    // Mostly a measurement tracking its setpoint, with full-range noise and corners
    task automatic queue_random_sample();
        int base;
        int noise;
        case ($urandom_range(0, 19))
            0, 1, 2: queue_sample($urandom(), $urandom());
            3: queue_sample(pick_corner(), pick_corner());
            default: begin
                base = $urandom_range(0, 1 << 23) - (1 << 22);
                noise = $urandom_range(0, 1 << 19) - (1 << 18);
                queue_sample(base, base + noise);
            end
        endcase
    endtask

    task automatic random_setting();
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] t;
        int          a;
        case ($urandom_range(0, 5))
            0: begin
                lo = 32'h8000_0000;
                hi = 32'h7FFF_FFFF;
            end
            1: begin
                // Crossed limits
                lo = $urandom();
                hi = $urandom();
                if ($signed(lo) < $signed(hi)) begin
                    t = lo;
                    lo = hi;
                    hi = t;
                end
            end
            default: begin
                a = $urandom_range(0, 1 << 27) - (1 << 26);
                lo = a;
                hi = a + $urandom_range(0, 1 << 27);
            end
        endcase
        apply_setting(pick_gain(), pick_gain(), pick_gain(), pick_step(), lo, hi);
    endtask

    // Hold the test sequence until every queued sample has produced its drive value
    task automatic wait_quiet();
        while (drives_checked != samples_queued) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Input stream driver: predict on each transfer, then load the next sample
    // ------------------------------------------------------------------
    always @(posedge clk) begin : sample_driver
        t_sample nxt;
        if (!rst_n) begin
            s_valid <= 1'b0;
            s_data <= '0;
        end else begin
            if (s_valid && s_ready) begin
                drive_expect_q.push_back(pid_drive(s_data[31:0], s_data[63:32]));
                samples_taken++;
            end
            // Hold a sample until it transfers; otherwise offer the next or idle
            if (!s_valid || s_ready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_q.pop_front();
                    s_valid <= 1'b1;
                    s_data <= {nxt.measurement, nxt.setpoint};
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Output backpressure
    always @(posedge clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: compare each drive transfer with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) begin
            if (drive_expect_q.size() == 0) begin
                flag_mismatch("drive with no sample outstanding", 'x, m_data);
            end else begin
                if (m_data !== drive_expect_q[0]) begin
                    flag_mismatch($sformatf("drive value %0d", drives_checked),
                                  drive_expect_q[0], m_data);
                end
                void'(drive_expect_q.pop_front());
                drives_checked++;
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || psel || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles, %0d drive values outstanding",
                     quiet_cycles, drive_expect_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : sequencer
        int idle_plan[4][2];
        idle_plan = '{'{0, 0}, '{63, 0}, '{0, 63}, '{22, 22}};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values of every register
        for (int r = REG_KP; r <= REG_OMAX; r++) begin
            check_reg(3'(r));
        end

        // Reset configuration: zero gains, so the drive sits on the lower clamp
        queue_sample(32'h0005_0000, 32'h0001_0000);
        wait_quiet();

        // Moderate gains, symmetric +/-100.0 clamp
        apply_setting(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 16'd655,
                      32'hFF9C_0000, 32'h0064_0000);
        queue_sample(32'h000A_0000, 32'h0000_0000);
        queue_sample(32'h0000_0000, 32'h000A_0000);
        queue_sample(32'h0000_0000, 32'h0000_0000);
        wait_quiet();

        // Extreme gains, zero sample period, widest clamp
        apply_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'd0,
                      32'h8000_0000, 32'h7FFF_FFFF);
        // Writes past the last register must leave everything unchanged
        program_reg(REG_SPARE_LO, $urandom());
        program_reg(REG_SPARE_HI, $urandom());
        for (int r = REG_KP; r <= REG_OMAX; r++) begin
            check_reg(3'(r));
        end
        queue_sample(32'h7FFF_FFFF, 32'h8000_0000);   // error saturates high
        queue_sample(32'h8000_0000, 32'h7FFF_FFFF);   // error saturates low
        queue_sample(32'h0000_0000, 32'h0000_0000);
        queue_sample(32'hFFFF_FFFF, 32'h0000_0000);
        queue_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_sample(32'h8000_0000, 32'h8000_0000);
        queue_sample(32'h0000_0001, 32'h0000_0000);
        wait_quiet();

        // Crossed clamp limits, longest sample period, largest positive kd
        apply_setting(32'h0001_0000, 32'h0000_0000, 32'h7FFF_FFFF, 16'hFFFF,
                      32'h0032_0000, 32'hFFCE_0000);
        queue_sample(32'h7FFF_FFFF, 32'h8000_0000);
        queue_sample(32'h0000_0000, 32'h0000_0000);
        queue_sample(32'h0064_0000, 32'h0000_0000);
        queue_sample(32'h8000_0000, 32'h0000_0000);
        wait_quiet();

        // Shortest nonzero sample period: the derivative is scaled by 2^16
        apply_setting(32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, 16'd1,
                      32'h8000_0000, 32'h7FFF_FFFF);
        queue_sample(32'h0001_0000, 32'h0000_0000);
        queue_sample(32'h0000_0000, 32'h0000_0000);
        queue_sample(32'hFFFF_0000, 32'h0000_0000);
        queue_sample(32'h0000_0001, 32'h0000_0000);
        wait_quiet();

        // Random part: four pacing modes, two settings each; the sender
        // drains completely before every register change
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_plan[ph][0];
            recv_stall_pct = idle_plan[ph][1];
            for (int blk = 0; blk < 2; blk++) begin
                random_setting();
                for (int n = 0; n < 85; n++) begin
                    queue_random_sample();
                end
                wait_quiet();
            end
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d samples and %0d drive values under %0d register settings,",
                 samples_taken, drives_checked, settings_applied);
        $display("with free-running, sender-idle, receiver-stall and mixed pacing.");
        if (mismatches == 0 && drive_expect_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: pid_controller_clamped.f
rtl/pcc_pkg.sv
rtl/pid_controller_clamped.sv
tb/pid_controller_clamped_tb.sv
